### design/crcd_pkg.sv
package crcd_pkg;

  localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_DELTA = 32'hA282_EAD8;
  // length field, length CRC and payload CRC add up to this many bytes per record
  localparam logic [63:0] FRAME_OVERHEAD = 64'd16;

  typedef enum logic {
    OP_BYTE      = 1'b0,
    OP_SHARD_END = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RK_PAYLOAD   = 2'd0,
    RK_VERIFIED  = 2'd1,
    RK_SHARD_END = 2'd2,
    RK_ERROR     = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    EC_NONE          = 3'd0,
    EC_LEN_CRC       = 3'd1,
    EC_PAY_CRC       = 3'd2,
    EC_TRUNC_LEN     = 3'd3,
    EC_TRUNC_LEN_CRC = 3'd4,
    EC_TRUNC_PAY     = 3'd5,
    EC_TRUNC_PAY_CRC = 3'd6
  } err_code_t;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_LEN_CRC = 2'd1,
    PH_PAY     = 2'd2,
    PH_PAY_CRC = 2'd3
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } crcd_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        last_payload_byte;
    logic [2:0]  error_code;
    logic [63:0] record_length;
    logic [63:0] record_offset;
  } crcd_out_t;

  // Reflected CRC-32C update over one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Finalize, rotate right by 15 and add the mask delta
  function automatic logic [31:0] crc32c_masked(input logic [31:0] crc);
    logic [31:0] c;
    c = crc ^ 32'hFFFF_FFFF;
    return {c[14:0], c[31:15]} + MASK_DELTA;
  endfunction

endpackage

### design/crcd_in_reg.sv
module crcd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  crcd_pkg::crcd_in_t in_item,
  input  logic              take,
  output logic              item_vld,
  output crcd_pkg::crcd_in_t item
);
  import crcd_pkg::*;

  logic     vld_r;
  crcd_in_t item_r;

  // Hold the item while the parser cannot take it
  assign in_stall = vld_r && !take;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### design/crcd_parse.sv
module crcd_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_vld,
  input  crcd_pkg::crcd_in_t item,
  output logic               res_vld,
  output crcd_pkg::crcd_out_t res
);
  import crcd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] length_r, length_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic        halted_r, halted_nxt;

  logic [31:0] crc_upd;
  logic [31:0] rcv_full;
  logic [31:0] crc_expect;
  logic [63:0] remain_dec;

  // Parser state, updated once per item taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      cnt_r    <= 3'd0;
      length_r <= 64'd0;
      remain_r <= 64'd0;
      crc_r    <= CRC_INIT;
      rcv_r    <= 32'd0;
      offset_r <= 64'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      length_r <= length_nxt;
      remain_r <= remain_nxt;
      crc_r    <= crc_nxt;
      rcv_r    <= rcv_nxt;
      offset_r <= offset_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign crc_upd    = crc32c_byte(crc_r, item.data_byte);
  assign rcv_full   = {item.data_byte, rcv_r[23:0]};
  assign crc_expect = crc32c_masked(crc_r);
  assign remain_dec = remain_r - 64'd1;

  // Decode one item and form its result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    length_nxt = length_r;
    remain_nxt = remain_r;
    crc_nxt    = crc_r;
    rcv_nxt    = rcv_r;
    offset_nxt = offset_r;
    halted_nxt = halted_r;

    res_vld               = 1'b0;
    res.result_kind       = RK_PAYLOAD;
    res.payload_byte      = 8'd0;
    res.last_payload_byte = 1'b0;
    res.error_code        = EC_NONE;
    res.record_length     = length_r;
    res.record_offset     = offset_r;

    if (item_vld) begin
      if (item.operation == OP_SHARD_END) begin
        // report how the shard ended unless halted after a CRC error, then start a fresh shard
        if (!halted_r) begin
          res_vld         = 1'b1;
          res.result_kind = RK_ERROR;
          unique case (phase_r)
            PH_LEN: begin
              res.record_length = 64'd0;
              if (cnt_r == 3'd0) begin
                res.result_kind = RK_SHARD_END;
              end else begin
                res.error_code = EC_TRUNC_LEN;
              end
            end
            PH_LEN_CRC: res.error_code = EC_TRUNC_LEN_CRC;
            PH_PAY:     res.error_code = EC_TRUNC_PAY;
            PH_PAY_CRC: res.error_code = EC_TRUNC_PAY_CRC;
          endcase
        end
        phase_nxt  = PH_LEN;
        cnt_nxt    = 3'd0;
        length_nxt = 64'd0;
        remain_nxt = 64'd0;
        crc_nxt    = CRC_INIT;
        rcv_nxt    = 32'd0;
        offset_nxt = 64'd0;
        halted_nxt = 1'b0;
      end else if (!halted_r) begin
        unique case (phase_r)
          PH_LEN: begin
            // collect the little-endian length
            length_nxt[{cnt_r, 3'b000} +: 8] = item.data_byte;
            crc_nxt = crc_upd;
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              phase_nxt = PH_LEN_CRC;
              cnt_nxt   = 3'd0;
              rcv_nxt   = 32'd0;
            end
          end
          PH_LEN_CRC: begin
            rcv_nxt[{cnt_r[1:0], 3'b000} +: 8] = item.data_byte;
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r == 3'd3) begin
              cnt_nxt = 3'd0;
              if (rcv_full != crc_expect) begin
                halted_nxt     = 1'b1;
                res_vld        = 1'b1;
                res.result_kind = RK_ERROR;
                res.error_code = EC_LEN_CRC;
              end else begin
                crc_nxt    = CRC_INIT;
                rcv_nxt    = 32'd0;
                remain_nxt = length_r;
                phase_nxt  = (length_r == 64'd0) ? PH_PAY_CRC : PH_PAY;
              end
            end
          end
          PH_PAY: begin
            // forward the byte as it arrives
            crc_nxt          = crc_upd;
            remain_nxt       = remain_dec;
            res_vld          = 1'b1;
            res.payload_byte = item.data_byte;
            if (remain_dec == 64'd0) begin
              phase_nxt             = PH_PAY_CRC;
              cnt_nxt               = 3'd0;
              rcv_nxt               = 32'd0;
              res.last_payload_byte = 1'b1;
            end
          end
          PH_PAY_CRC: begin
            rcv_nxt[{cnt_r[1:0], 3'b000} +: 8] = item.data_byte;
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r == 3'd3) begin
              res_vld = 1'b1;
              if (rcv_full != crc_expect) begin
                cnt_nxt         = 3'd0;
                halted_nxt      = 1'b1;
                res.result_kind = RK_ERROR;
                res.error_code  = EC_PAY_CRC;
              end else begin
                // close the record and advance to the next one
                res.result_kind = RK_VERIFIED;
                offset_nxt = offset_r + FRAME_OVERHEAD + length_r;
                phase_nxt  = PH_LEN;
                cnt_nxt    = 3'd0;
                length_nxt = 64'd0;
                remain_nxt = 64'd0;
                crc_nxt    = CRC_INIT;
                rcv_nxt    = 32'd0;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

### design/crcd_out_reg.sv
module crcd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_vld,
  input  crcd_pkg::crcd_out_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output crcd_pkg::crcd_out_t out_item
);
  import crcd_pkg::*;

  logic      vld_r;
  crcd_out_t item_r;

  // Load a new result when the register is empty or being drained
  assign out_free  = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_vld) begin
      item_r <= res;
    end
  end

endmodule

### design/crc_checked_record_deframer.sv
// Record deframer with masked CRC-32C checks.
// Input channel (in_valid / in_stall / in_item): one item per cycle while in_stall
// is low, either a stream byte or an end-of-shard marker. Records are an 8-byte
// little-endian length, a 4-byte masked CRC of it, the payload and a 4-byte
// masked CRC of the payload.
// Result channel (out_valid / out_stall / out_item): zero or one result per
// item: each payload byte as it arrives (last one flagged), then a verified or
// error result per record, and a clean-end or truncation result per shard end.
// After a CRC error, bytes are dropped silently until the next shard end.
// Path: an accepted item is held in the input register; when the output register
// is free, its result is loaded into the output register, so it passes the input
// register, then the parse logic into the output register.
// Throughput: one item per cycle when the receiver does not stall; the CRC-32C byte
// update and the 64-bit length counter are settled combinationally between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to a record boundary at offset zero.
// When the receiver stalls, the output register holds its result; in_stall
// rises once the input register also holds an item, and no item is lost.
module crc_checked_record_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crcd_pkg::crcd_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crcd_pkg::crcd_out_t out_item
);
  import crcd_pkg::*;

  logic      item_vld;
  crcd_in_t  item;
  logic      take;
  logic      out_free;
  logic      res_vld;
  crcd_out_t res;

  // Advance the held item when the output register can take its result
  assign take = item_vld && out_free;

  crcd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  crcd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (take),
    .item     (item),
    .res_vld  (res_vld),
    .res      (res)
  );

  crcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Input backpressure only comes from a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && item_vld))
    else $error("input stalled without a blocked result");

  // Error code is set exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.result_kind == RK_ERROR) == (out_item.error_code != EC_NONE)))
    else $error("error code does not match result kind");

  // Last-byte flag only on payload results
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_payload_byte) |-> (out_item.result_kind == RK_PAYLOAD))
    else $error("last flag on non-payload result");

  // A taken item that yields a result shows up in the next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_vld) |=> out_valid)
    else $error("result lost between parser and output register");

endmodule

### tb/testbench.sv
module testbench;
  import crcd_pkg::*;

  localparam int          RANDOM_ITEMS   = 225;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = 10;
  localparam int          HOLD_AT_ITEM   = 300;
  localparam int          HOLD_CYCLES    = 250;
  localparam int          REPORT_CAP     = 30;
  localparam logic [63:0] NO_CUT         = 64'hFFFF_FFFF_FFFF_FFFF;

  // record flaws the stimulus can inject
  localparam int FLAW_NONE    = 0;
  localparam int FLAW_LEN_CRC = 1;
  localparam int FLAW_PAY_CRC = 2;

  typedef struct {
    crcd_in_t item;
    bit       drain_first;
  } stream_entry_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  crcd_in_t  in_item;
  logic      out_valid;
  logic      out_stall;
  crcd_out_t out_item;

  crc_checked_record_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_entry_t stream_q[$];
  crcd_out_t     frame_results_q[$];
  bit            drain_next;

  // deframer shadow state
  phase_t      ph;
  int unsigned field_cnt;
  logic [63:0] rec_len;
  logic [63:0] left;
  logic [31:0] run_crc;
  logic [31:0] got_crc;
  logic [63:0] shard_offset;
  bit          halted;

  int mismatches;
  int results_seen;
  int accepted_in;
  int idle_cycles;
  bit in_took;
  int in_gap;
  int tx_calm;
  int stall_left;
  int rx_calm;
  int hold_left;
  bit hold_done;

  // reflected CRC-32C over one byte, one bit per step
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'h0, b};
    repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  // finish, rotate right 15, add delta
  function automatic logic [31:0] crc_mask(input logic [31:0] acc);
    logic [31:0] f;
    f = ~acc;
    return ((f >> 15) | (f << 17)) + MASK_DELTA;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int draw_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm = $urandom_range(150, 40);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int unsigned pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(6, 0);
    if (roll < 95) return $urandom_range(24, 7);
    return $urandom_range(64, 25);
  endfunction

  task automatic open_record();
    ph        = PH_LEN;
    field_cnt = 0;
    rec_len   = '0;
    left      = '0;
    run_crc   = CRC_INIT;
    got_crc   = '0;
  endtask

  // advance the shadow deframer by one item and queue what it yields
  task automatic deframe_step(input crcd_in_t it);
    crcd_out_t r;
    bit        gives;
    r = '0;
    r.record_offset = shard_offset;
    gives = 1'b0;
    if (it.operation == OP_SHARD_END) begin
      if (!halted) begin
        gives = 1'b1;
        if (ph == PH_LEN && field_cnt == 0) begin
          r.result_kind = RK_SHARD_END;
        end else begin
          r.result_kind = RK_ERROR;
          case (ph)
            PH_LEN:     r.error_code = EC_TRUNC_LEN;
            PH_LEN_CRC: r.error_code = EC_TRUNC_LEN_CRC;
            PH_PAY:     r.error_code = EC_TRUNC_PAY;
            default:    r.error_code = EC_TRUNC_PAY_CRC;
          endcase
          if (ph != PH_LEN) r.record_length = rec_len;
        end
      end
      open_record();
      shard_offset = '0;
      halted = 1'b0;
    end else if (!halted) begin
      case (ph)
        PH_LEN: begin
          rec_len = rec_len | (64'(it.data_byte) << (8 * field_cnt));
          run_crc = crc_step(run_crc, it.data_byte);
          field_cnt++;
          if (field_cnt == 8) begin
            ph = PH_LEN_CRC;
            field_cnt = 0;
            got_crc = '0;
          end
        end
        PH_LEN_CRC: begin
          got_crc = got_crc | (32'(it.data_byte) << (8 * field_cnt));
          field_cnt++;
          if (field_cnt == 4) begin
            field_cnt = 0;
            if (got_crc != crc_mask(run_crc)) begin
              halted = 1'b1;
              gives = 1'b1;
              r.result_kind = RK_ERROR;
              r.error_code = EC_LEN_CRC;
              r.record_length = rec_len;
            end else begin
              run_crc = CRC_INIT;
              got_crc = '0;
              left = rec_len;
              ph = (rec_len == 0) ? PH_PAY_CRC : PH_PAY;
            end
          end
        end
        PH_PAY: begin
          run_crc = crc_step(run_crc, it.data_byte);
          left = left - 1;
          gives = 1'b1;
          r.result_kind = RK_PAYLOAD;
          r.payload_byte = it.data_byte;
          r.record_length = rec_len;
          if (left == 0) begin
            r.last_payload_byte = 1'b1;
            ph = PH_PAY_CRC;
            field_cnt = 0;
            got_crc = '0;
          end
        end
        default: begin
          got_crc = got_crc | (32'(it.data_byte) << (8 * field_cnt));
          field_cnt++;
          if (field_cnt == 4) begin
            gives = 1'b1;
            r.record_length = rec_len;
            if (got_crc != crc_mask(run_crc)) begin
              field_cnt = 0;
              halted = 1'b1;
              r.result_kind = RK_ERROR;
              r.error_code = EC_PAY_CRC;
            end else begin
              r.result_kind = RK_VERIFIED;
              shard_offset = shard_offset + FRAME_OVERHEAD + rec_len;
              open_record();
            end
          end
        end
      endcase
    end
    if (gives) frame_results_q = {frame_results_q, r};
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic check_result(input crcd_out_t got);
    crcd_out_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result with nothing pending, kind", 64'(got.result_kind), 64'd0);
      return;
    end
    want = frame_results_q.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
    if (got.last_payload_byte !== want.last_payload_byte)
      report_mismatch("last_payload_byte", 64'(got.last_payload_byte),
                      64'(want.last_payload_byte));
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
    if (got.record_length !== want.record_length)
      report_mismatch("record_length", got.record_length, want.record_length);
    if (got.record_offset !== want.record_offset)
      report_mismatch("record_offset", got.record_offset, want.record_offset);
  endtask

  task automatic push_item(input op_t op, input logic [7:0] b);
    stream_entry_t e;
    e.item.operation = op;
    e.item.data_byte = b;
    e.drain_first = drain_next;
    drain_next = 1'b0;
    stream_q = {stream_q, e};
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_item(OP_BYTE, 8'($urandom));
  endtask

  // emit one record byte by byte; stop at cut and close the shard there
  task automatic add_record(input logic [63:0] len, input int flaw, input logic [63:0] cut);
    logic [31:0] lcrc;
    logic [31:0] pcrc;
    logic [31:0] lmask;
    logic [31:0] pmask;
    logic [63:0] i;
    logic [7:0]  b;
    bit          done;
    lcrc = CRC_INIT;
    pcrc = CRC_INIT;
    lmask = '0;
    pmask = '0;
    done = 1'b0;
    i = '0;
    while (!done && i != cut) begin
      if (i < 8) begin
        b = 8'(len >> (8 * i));
        lcrc = crc_step(lcrc, b);
        if (i == 7) begin
          lmask = crc_mask(lcrc);
          if (flaw == FLAW_LEN_CRC) lmask = lmask ^ (32'd1 << $urandom_range(31));
        end
      end else if (i < 12) begin
        b = 8'(lmask >> (8 * (i - 8)));
      end else if (i - 12 < len) begin
        b = 8'($urandom);
        pcrc = crc_step(pcrc, b);
      end else begin
        if (i - 12 == len) begin
          pmask = crc_mask(pcrc);
          if (flaw == FLAW_PAY_CRC) pmask = pmask ^ (32'd1 << $urandom_range(31));
        end
        b = 8'(pmask >> (8 * (i - 12 - len)));
        done = (i - 12 - len == 3);
      end
      push_item(OP_BYTE, b);
      i = i + 1;
    end
    if (!done) push_item(OP_SHARD_END, 8'($urandom));
  endtask

  // drive the input channel at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (stream_q.size() != 0 &&
                   !(stream_q[0].drain_first && frame_results_q.size() != 0)) begin
        in_valid <= 1'b1;
        in_item <= stream_q[0].item;
        in_gap = draw_gap(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // drive the result stall: random gaps plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && accepted_in >= HOLD_AT_ITEM) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = draw_gap(rx_calm);
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        check_result(out_item);
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        deframe_step(in_item);
        void'(stream_q.pop_front());
        accepted_in++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    int          roll;
    int          directed_items;
    int unsigned len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    mismatches = 0;
    results_seen = 0;
    accepted_in = 0;
    idle_cycles = 0;
    in_gap = 0;
    tx_calm = 0;
    stall_left = 0;
    rx_calm = 0;
    hold_left = 0;
    hold_done = 1'b0;
    drain_next = 1'b0;
    open_record();
    shard_offset = '0;
    halted = 1'b0;

    // directed: clean ends, empty payload, both CRC errors, every truncation
    push_item(OP_SHARD_END, 8'hFF);
    add_record(64'd0, FLAW_NONE, NO_CUT);
    add_record(64'd1, FLAW_NONE, NO_CUT);
    add_record(64'd5, FLAW_NONE, NO_CUT);
    push_item(OP_SHARD_END, 8'h00);
    push_item(OP_SHARD_END, 8'hA5);
    add_record(64'd2, FLAW_LEN_CRC, NO_CUT);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_SHARD_END, 8'h5A);
    add_record(64'd3, FLAW_PAY_CRC, NO_CUT);
    push_noise(3);
    push_item(OP_SHARD_END, 8'h00);
    add_record(64'd4, FLAW_NONE, 64'd3);
    add_record(64'd4, FLAW_NONE, 64'd8);
    add_record(64'd4, FLAW_NONE, 64'd10);
    add_record(64'd4, FLAW_NONE, 64'd14);
    add_record(64'd2, FLAW_NONE, 64'd14);
    add_record(64'd2, FLAW_NONE, 64'd17);
    add_record(64'd0, FLAW_NONE, NO_CUT);
    add_record(64'hFFFF_FFFF_FFFF_FFFF, FLAW_NONE, 64'd20);
    add_record(64'h8000_0000_0000_0000, FLAW_NONE, 64'd12);
    directed_items = stream_q.size();

    // random: mostly well-formed records, some broken ones and noise
    drain_next = 1'b1;
    while (stream_q.size() < directed_items + RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      len = pick_length();
      if ($urandom_range(15) == 0) drain_next = 1'b1;
      if (roll < 60) begin
        add_record(64'(len), FLAW_NONE, NO_CUT);
      end else if (roll < 68) begin
        add_record(64'(len), FLAW_LEN_CRC, NO_CUT);
        push_noise($urandom_range(4, 0));
        push_item(OP_SHARD_END, 8'($urandom));
      end else if (roll < 76) begin
        add_record(64'(len), FLAW_PAY_CRC, NO_CUT);
        push_noise($urandom_range(4, 0));
        push_item(OP_SHARD_END, 8'($urandom));
      end else if (roll < 88) begin
        add_record(64'(len), FLAW_NONE, 64'($urandom_range(15 + len, 0)));
      end else if (roll < 94) begin
        push_item(OP_SHARD_END, 8'($urandom));
      end else begin
        push_noise($urandom_range(20, 1));
        push_item(OP_SHARD_END, 8'($urandom));
      end
    end
    push_item(OP_SHARD_END, 8'($urandom));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // wait for the stream to drain and every result to arrive
    while ((stream_q.size() != 0 || frame_results_q.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, frame_results_q.size());
      $display("== FAIL ==");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (mismatches == 0 && frame_results_q.size() == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule
